### rtl/hse_pkg.sv
package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_W     = 32;
    localparam int AW        = $clog2(MAX_ITEMS);
    localparam int CW        = $clog2(MAX_ITEMS + 1);
    localparam int XW        = AW + 2;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int CFG_IW    = 1;
    localparam int CFG_DW    = 1;

    localparam logic [CFG_IW-1:0] CFG_DESCENDING  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_SIGNED_KEYS = 1'b1;

    typedef struct packed {
        logic [31:0] key;
        logic        last;
    } t_in_req;

    typedef struct packed {
        logic [31:0] sorted_key;
        logic        final_res;
        logic        overflow;
    } t_out_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             store;
        logic             last;
        logic             ovf;
    } t_cmd;

    typedef struct packed {
        logic descending;
        logic signed_keys;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // true when a sorts strictly before b
    function automatic logic f_before(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input t_cfg cfg);
        logic [KEY_W-1:0] ax;
        logic [KEY_W-1:0] bx;
        ax = a ^ {cfg.signed_keys, {(KEY_W-1){1'b0}}};
        bx = b ^ {cfg.signed_keys, {(KEY_W-1){1'b0}}};
        return cfg.descending ? (ax > bx) : (ax < bx);
    endfunction

endpackage

### rtl/hse_ram.sv
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hse_queue.sv
module hse_queue
    import hse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_push_data,
    input  logic    i_pop,
    output t_cmd    o_pop_data,
    output t_q_stat o_stat
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

### rtl/hse_front.sv
module hse_front
    import hse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in_req i_in_data,
    output logic    o_in_stall,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cmd    o_push_data
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_drop;
    logic          n_drop;
    logic          w_accept;
    logic          w_store;
    logic          w_ovf;

    assign w_accept = i_in_valid && !i_q_stat.full;
    assign w_store  = (r_count < CW'(MAX_ITEMS));
    assign w_ovf    = r_drop || !w_store;

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (w_accept) begin
            if (i_in_data.last) begin
                n_count = '0;
                n_drop  = 1'b0;
            end else begin
                n_count = r_count + CW'(w_store);
                n_drop  = w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    assign o_in_stall        = i_q_stat.full;
    assign o_push            = w_accept;
    assign o_push_data.key   = i_in_data.key[KEY_W-1:0];
    assign o_push_data.store = w_store;
    assign o_push_data.last  = i_in_data.last;
    assign o_push_data.ovf   = w_ovf;

endmodule

### rtl/hse_back.sv
module hse_back
    import hse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_q_stat  i_q_stat,
    output logic     o_pop,
    input  t_cmd     i_pop_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    typedef enum logic [11:0] {
        S_LOAD   = 12'b0000_0000_0001,
        S_BSTART = 12'b0000_0000_0010,
        S_RDV    = 12'b0000_0000_0100,
        S_SIFT   = 12'b0000_0000_1000,
        S_RDL    = 12'b0000_0001_0000,
        S_RDR    = 12'b0000_0010_0000,
        S_CMP    = 12'b0000_0100_0000,
        S_XSTART = 12'b0000_1000_0000,
        S_XRD0   = 12'b0001_0000_0000,
        S_XRD1   = 12'b0010_0000_0000,
        S_ERD    = 12'b0100_0000_0000,
        S_EOUT   = 12'b1000_0000_0000
    } t_state;

    t_state           r_state,   n_state;
    logic [CW-1:0]    r_wcnt,    n_wcnt;
    logic [CW-1:0]    r_n,       n_n;
    logic [CW-1:0]    r_end,     n_end;
    logic [CW-1:0]    r_top,     n_top;
    logic [AW-1:0]    r_node,    n_node;
    logic [AW-1:0]    r_idx,     n_idx;
    logic [KEY_W-1:0] r_v,       n_v;
    logic [KEY_W-1:0] r_l,       n_l;
    logic [KEY_W-1:0] r_r,       n_r;
    logic [KEY_W-1:0] r_tmp,     n_tmp;
    logic             r_pick,    n_pick;
    logic             r_extract, n_extract;
    logic             r_ovf,     n_ovf;
    logic             r_ovalid,  n_ovalid;
    t_out_req         r_odata,   n_odata;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [KEY_W-1:0] w_rdata;

    logic [CW-1:0]    w_cnt_after;
    logic [CW-1:0]    w_top_m1;
    logic [CW-1:0]    w_end_m1;
    logic [XW-1:0]    w_cl;
    logic [XW-1:0]    w_cr;
    logic [XW-1:0]    w_endx;
    logic [XW-1:0]    w_ci;
    logic [KEY_W-1:0] w_c;
    logic             w_out_free;
    logic             w_final;

    hse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cnt_after = r_wcnt + CW'(i_pop_data.store);
    assign w_top_m1    = r_top - 1'b1;
    assign w_end_m1    = r_end - 1'b1;
    assign w_cl        = {1'b0, r_node, 1'b1};
    assign w_cr        = w_cl + 1'b1;
    assign w_endx      = XW'(r_end);
    assign w_c         = r_pick ? r_r : r_l;
    assign w_ci        = r_pick ? w_cr : w_cl;
    assign w_out_free  = !r_ovalid || !i_out_stall;
    assign w_final     = ((CW'(r_idx) + CW'(1)) == r_n);

    always_comb begin
        n_state   = r_state;
        n_wcnt    = r_wcnt;
        n_n       = r_n;
        n_end     = r_end;
        n_top     = r_top;
        n_node    = r_node;
        n_idx     = r_idx;
        n_v       = r_v;
        n_l       = r_l;
        n_r       = r_r;
        n_tmp     = r_tmp;
        n_pick    = r_pick;
        n_extract = r_extract;
        n_ovf     = r_ovf;
        n_ovalid  = r_ovalid && i_out_stall;
        n_odata   = r_odata;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_node;
        w_wdata   = r_v;
        w_raddr   = '0;

        unique case (r_state)
            S_LOAD: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    w_we    = i_pop_data.store;
                    w_waddr = r_wcnt[AW-1:0];
                    w_wdata = i_pop_data.key;
                    n_wcnt  = w_cnt_after;
                    if (i_pop_data.last) begin
                        n_n       = w_cnt_after;
                        n_end     = w_cnt_after;
                        n_top     = w_cnt_after >> 1;
                        n_ovf     = i_pop_data.ovf;
                        n_extract = 1'b0;
                        n_state   = S_BSTART;
                    end
                end
            end
            S_BSTART: begin
                if (r_top == '0) begin
                    n_extract = 1'b1;
                    n_state   = S_XSTART;
                end else begin
                    n_top   = w_top_m1;
                    n_node  = w_top_m1[AW-1:0];
                    w_raddr = w_top_m1[AW-1:0];
                    n_state = S_RDV;
                end
            end
            S_RDV: begin
                n_v     = w_rdata;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                if (w_cl < w_endx) begin
                    w_raddr = w_cl[AW-1:0];
                    n_state = S_RDL;
                end else begin
                    w_we    = 1'b1;
                    n_state = r_extract ? S_XSTART : S_BSTART;
                end
            end
            S_RDL: begin
                n_l = w_rdata;
                if (w_cr < w_endx) begin
                    w_raddr = w_cr[AW-1:0];
                    n_state = S_RDR;
                end else begin
                    n_pick  = 1'b0;
                    n_state = S_CMP;
                end
            end
            S_RDR: begin
                n_r     = w_rdata;
                n_pick  = f_before(r_l, w_rdata, i_cfg);
                n_state = S_CMP;
            end
            S_CMP: begin
                w_we = 1'b1;
                if (f_before(r_v, w_c, i_cfg)) begin
                    w_wdata = w_c;
                    n_node  = w_ci[AW-1:0];
                    n_state = S_SIFT;
                end else begin
                    n_state = r_extract ? S_XSTART : S_BSTART;
                end
            end
            S_XSTART: begin
                if (r_end <= CW'(1)) begin
                    n_idx   = '0;
                    n_state = S_ERD;
                end else begin
                    n_state = S_XRD0;
                end
            end
            S_XRD0: begin
                n_tmp   = w_rdata;
                w_raddr = w_end_m1[AW-1:0];
                n_state = S_XRD1;
            end
            S_XRD1: begin
                w_we    = 1'b1;
                w_waddr = w_end_m1[AW-1:0];
                w_wdata = r_tmp;
                n_v     = w_rdata;
                n_end   = w_end_m1;
                n_node  = '0;
                n_state = S_SIFT;
            end
            S_ERD: begin
                w_raddr = r_idx;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                w_raddr = r_idx;
                if (w_out_free) begin
                    n_ovalid           = 1'b1;
                    n_odata.sorted_key = w_rdata;
                    n_odata.final_res  = w_final;
                    n_odata.overflow   = r_ovf;
                    if (w_final) begin
                        n_wcnt  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_wcnt    <= '0;
            r_extract <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wcnt    <= n_wcnt;
            r_extract <= n_extract;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_end   <= n_end;
        r_top   <= n_top;
        r_node  <= n_node;
        r_idx   <= n_idx;
        r_v     <= n_v;
        r_l     <= n_l;
        r_r     <= n_r;
        r_tmp   <= n_tmp;
        r_pick  <= n_pick;
        r_ovf   <= n_ovf;
        r_odata <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

### rtl/heap_sort_engine.sv
// channel  dir  valid        stall        payload
// in       in   i_in_valid   o_in_stall   i_in_data  (key, last)
// out      out  o_out_valid  i_out_stall  o_out_data (sorted_key, final_res, overflow)
// cfg      in   i_cfg_we     -            i_cfg_idx, i_cfg_data
//
// Keys enter one per cycle through a 4-entry queue unless it is full; the back end stores
// one per cycle in S_LOAD while the queue holds keys. Sort: sifts go level by level through
// one RAM read port, n/2 build sifts plus n-1 extract sifts; readout uses S_ERD then S_EOUT.
// Reset clears control state and config; the key store needs no clearing.
// Input stalls only while the queue is full; the output register holds while stalled.
module heap_sort_engine
    import hse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_req           i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_req          o_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_q_stat w_q_stat;
    t_cmd    w_push_data;
    t_cmd    w_pop_data;
    logic    w_push;
    logic    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DESCENDING:  r_cfg.descending  <= i_cfg_data[0];
                CFG_SIGNED_KEYS: r_cfg.signed_keys <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    hse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    hse_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    hse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_pop_data  (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/hse_checker.sv
module hse_checker
    import hse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  t_out_req          o_out_data
);

    logic w_out_acc;

    assign w_out_acc = o_out_valid && !i_out_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result payload changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    a_ovf_same_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !o_out_data.final_res
            |=> !o_out_valid || (o_out_data.overflow == $past(o_out_data.overflow)))
        else $error("overflow flag changed within a set");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/heap_sort_engine_tb.sv
`timescale 1ns / 100ps

module heap_sort_engine_tb;
    import hse_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;
    localparam int PHASE_KEYS  = 3;

    typedef struct packed {
        logic [31:0] key;
        logic        last;
        logic        typed;
        logic [31:0] want;
    } t_row;

    // single-key sets carry their result inline; longer sets go through the sorter model
    localparam t_row DIR_ROWS [17] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0}
    };

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    t_in_req           i_in_data  = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_req          o_out_data;
    logic              i_cfg_we   = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx  = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    heap_sort_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // sorter model state
    logic [31:0] set_keys [$];
    bit          set_dropped = 1'b0;
    bit          ord_desc    = 1'b0;
    bit          ord_signed  = 1'b0;
    t_out_req    sorted_q [$];

    int          mismatches  = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    int          hold_left   = 0;

    function automatic bit goes_first(input logic [31:0] a, input logic [31:0] b);
        bit lt;
        bit gt;
        if (ord_signed) begin
            lt = $signed(a) < $signed(b);
            gt = $signed(a) > $signed(b);
        end else begin
            lt = a < b;
            gt = a > b;
        end
        return ord_desc ? gt : lt;
    endfunction

    function automatic void order_set();
        logic [31:0] k;
        int          j;
        for (int i = 1; i < set_keys.size(); i++) begin
            k = set_keys[i];
            j = i;
            while (j > 0 && goes_first(k, set_keys[j-1])) begin
                set_keys[j] = set_keys[j-1];
                j--;
            end
            set_keys[j] = k;
        end
    endfunction

    function automatic void take_key(input logic [31:0] k, input logic lst);
        t_out_req r;
        if (set_keys.size() < MAX_ITEMS)
            set_keys.push_back(k);
        else
            set_dropped = 1'b1;
        if (lst) begin
            order_set();
            foreach (set_keys[i]) begin
                r.sorted_key = set_keys[i];
                r.final_res  = (i == set_keys.size() - 1);
                r.overflow   = set_dropped;
                sorted_q.push_back(r);
            end
            set_keys.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(15);
            2:       return 32'h8000_0000 + $urandom_range(16) - 8;
            default: return 32'hFFFF_FFF0 | $urandom_range(15);
        endcase
    endfunction

    task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
        mismatches++;
    endtask

    // result side: check, then pick the next stall
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = sorted_q.pop_front();
                    if (o_out_data.sorted_key !== want.sorted_key)
                        report("sorted_key", want.sorted_key, o_out_data.sorted_key);
                    if (o_out_data.final_res !== want.final_res)
                        report("final_res", 32'(want.final_res), 32'(o_out_data.final_res));
                    if (o_out_data.overflow !== want.overflow)
                        report("overflow", 32'(want.overflow), 32'(o_out_data.overflow));
                end
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_key(input logic [31:0] k, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{key: k, last: lst};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_set(input int n);
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            k = pick_key();
            send_key(k, i == n - 1);
            take_key(k, i == n - 1);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_order(input bit desc, input bit sgn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DESCENDING;
        i_cfg_data <= desc;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SIGNED_KEYS;
        i_cfg_data <= sgn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ord_desc   = desc;
        ord_signed = sgn;
    endtask

    initial begin
        bit ph_desc   [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
        bit ph_signed [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
        int ph_tx     [4] = '{9, 77, 0, 0};
        int ph_rx     [4] = '{77, 9, 0, 0};
        int ph_big    [4] = '{0, 0, 0, 65};
        int sent;
        int n;

        repeat (10) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct = 9;
        rx_idle_pct <= 77;
        @(posedge i_clk);

        foreach (DIR_ROWS[r]) begin
            send_key(DIR_ROWS[r].key, DIR_ROWS[r].last);
            if (DIR_ROWS[r].typed)
                sorted_q.push_back('{sorted_key: DIR_ROWS[r].want, final_res: 1'b1,
                                     overflow: 1'b0});
            else
                take_key(DIR_ROWS[r].key, DIR_ROWS[r].last);
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            set_order(ph_desc[ph], ph_signed[ph]);
            tx_idle_pct = ph_tx[ph];
            rx_idle_pct <= ph_rx[ph];
            // long receiver hold-off while keys keep coming
            if (ph == 3)
                hold_req <= 1'b1;
            sent = 0;
            while (sent < PHASE_KEYS) begin
                n = $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
            send_set(ph_big[ph]);
            send_set($urandom_range(1, 4));
        end

        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/hse_pkg.sv
rtl/hse_ram.sv
rtl/hse_queue.sv
rtl/hse_front.sv
rtl/hse_back.sv
rtl/heap_sort_engine.sv
rtl/hse_checker.sv
tb/heap_sort_engine_tb.sv
